// ===== src/cbp_pkg.sv =====
// Shared types, constants, weight tables and the microcode program of the budget controller.
package cbp_pkg;

   // Field and datapath widths.
   localparam int COUNT_FIELD_W = 24;
   localparam int COUNT_BITS    = 24;
   localparam int COST_W        = 16;
   localparam int GAIN_W        = 16;
   localparam int SET_W         = 42;
   localparam int FRAME_W       = 16;
   localparam int POC_W         = 16;
   localparam int BUDGET_W      = 48;
   localparam int ACH_W         = 42;
   localparam int ERR_W         = 44;
   localparam int SUM_W         = 48;
   localparam int DIFF_W        = 45;
   localparam int V_W           = 51;
   localparam int WT_W          = 10;
   localparam int OFF_W         = 4;
   localparam int OFF_LIMIT     = 8;

   // Shared multiplier: signed 17 x 27 bits, wide operands split into 26-bit chunks.
   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 27;
   localparam int CHUNK_W = 26;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 66;

   // Frame numbers in this window force the controller off.
   localparam int FRAME_HOLD_LO = 64;
   localparam int FRAME_HOLD_HI = 128;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 42;

   // Microcode program.
   localparam int STEP_W = 5;

   localparam logic [COUNT_FIELD_W-1:0] COUNT_MASK =
      COUNT_FIELD_W'((64'd1 << COUNT_BITS) - 64'd1);

   // Group-position weights in Q2.8.
   localparam logic [WT_W-1:0] WEIGHT8 [8] = '{10'd666, 10'd333, 10'd220, 10'd166,
                                               10'd166, 10'd220, 10'd166, 10'd166};
   localparam logic [WT_W-1:0] WEIGHT4 [4] = '{10'd154, 10'd230, 10'd154, 10'd461};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SETPOINT       = 3'd0,
      REG_GAIN_P         = 3'd1,
      REG_GAIN_I         = 3'd2,
      REG_GAIN_D         = 3'd3,
      REG_COST_SAD       = 3'd4,
      REG_COST_SSE       = 3'd5,
      REG_COST_SATD      = 3'd6,
      REG_COST_TRANSFORM = 3'd7
   } cbp_reg_type;

   typedef struct packed {
      logic [COUNT_FIELD_W-1:0] sad_ops;
      logic [COUNT_FIELD_W-1:0] sse_ops;
      logic [COUNT_FIELD_W-1:0] satd_ops;
      logic [COUNT_FIELD_W-1:0] transform_ops;
      logic [FRAME_W-1:0]       frame_number;
      logic [POC_W-1:0]         picture_order;
      logic                     group_is_eight;
   } cbp_req_type;

   typedef struct packed {
      logic [BUDGET_W-1:0] budget;
      logic                control_on;
   } cbp_rsp_type;

   typedef struct packed {
      logic [SET_W-1:0]  setpoint;
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [COST_W-1:0] cost_sad;
      logic [COST_W-1:0] cost_sse;
      logic [COST_W-1:0] cost_satd;
      logic [COST_W-1:0] cost_transform;
   } cbp_cfg_type;

   // Multiplier operand selects.
   typedef enum logic [2:0] {
      MA_COST_SAD, MA_COST_SSE, MA_COST_SATD, MA_COST_TRANSFORM,
      MA_GAIN_P, MA_GAIN_I, MA_GAIN_D, MA_WEIGHT
   } cbp_mul_a_type;

   typedef enum logic [3:0] {
      MB_N_SAD, MB_N_SSE, MB_N_SATD, MB_N_TRANSFORM,
      MB_ERR_LO, MB_ERR_HI, MB_SUM_LO, MB_SUM_HI,
      MB_DIFF_LO, MB_DIFF_HI, MB_V_LO, MB_V_HI
   } cbp_mul_b_type;

   // Datapath operations other than multiply-accumulate.
   typedef enum logic [2:0] {
      ALU_NONE, ALU_DECIDE, ALU_SUM, ALU_VALUE, ALU_BUDGET
   } cbp_alu_type;

   // Sequencing of the step counter.
   typedef enum logic [1:0] {
      JMP_NEXT, JMP_END, JMP_END_IF_BYPASS
   } cbp_jump_type;

   typedef struct packed {
      cbp_mul_a_type mul_a;
      cbp_mul_b_type mul_b;
      logic          mul_en;
      logic          acc_load;
      logic          shift_hi;
      cbp_alu_type   alu;
      cbp_jump_type  jump;
   } cbp_uop_type;

   typedef struct packed {
      logic        exec;
      cbp_uop_type uop;
   } cbp_ctrl_type;

   // Build one control word.
   function automatic cbp_uop_type cbp_uop(input cbp_mul_a_type a, input cbp_mul_b_type b,
                                           input logic en, input logic ld, input logic hi,
                                           input cbp_alu_type alu, input cbp_jump_type jump);
      cbp_uop_type u;
      u.mul_a    = a;
      u.mul_b    = b;
      u.mul_en   = en;
      u.acc_load = ld;
      u.shift_hi = hi;
      u.alu      = alu;
      u.jump     = jump;
      return u;
   endfunction

   // Program ROM. A product is registered before it is added into the accumulator.
   function automatic cbp_uop_type cbp_ucode(input logic [STEP_W-1:0] step);
      cbp_uop_type u;
      case (step)
         // Achieved cost: four counts times their cost registers.
         5'd0:  u = cbp_uop(MA_COST_SAD, MB_N_SAD, 1'b1, 1'b1, 1'b0, ALU_NONE, JMP_NEXT);
         5'd1:  u = cbp_uop(MA_COST_SSE, MB_N_SSE, 1'b1, 1'b0, 1'b0, ALU_NONE, JMP_NEXT);
         5'd2:  u = cbp_uop(MA_COST_SATD, MB_N_SATD, 1'b1, 1'b0, 1'b0, ALU_NONE, JMP_NEXT);
         5'd3:  u = cbp_uop(MA_COST_TRANSFORM, MB_N_TRANSFORM, 1'b1, 1'b0, 1'b0,
                            ALU_NONE, JMP_NEXT);
         5'd4:  u = cbp_uop(MA_COST_SAD, MB_N_SAD, 1'b0, 1'b0, 1'b0, ALU_NONE, JMP_NEXT);
         // Bypass test and off counter; leaves early on bypass.
         5'd5:  u = cbp_uop(MA_COST_SAD, MB_N_SAD, 1'b0, 1'b0, 1'b0, ALU_DECIDE,
                            JMP_END_IF_BYPASS);
         // PID terms.
         5'd6:  u = cbp_uop(MA_GAIN_P, MB_ERR_LO, 1'b1, 1'b1, 1'b0, ALU_SUM, JMP_NEXT);
         5'd7:  u = cbp_uop(MA_GAIN_P, MB_ERR_HI, 1'b1, 1'b0, 1'b1, ALU_NONE, JMP_NEXT);
         5'd8:  u = cbp_uop(MA_GAIN_I, MB_SUM_LO, 1'b1, 1'b0, 1'b0, ALU_NONE, JMP_NEXT);
         5'd9:  u = cbp_uop(MA_GAIN_I, MB_SUM_HI, 1'b1, 1'b0, 1'b1, ALU_NONE, JMP_NEXT);
         5'd10: u = cbp_uop(MA_GAIN_D, MB_DIFF_LO, 1'b1, 1'b0, 1'b0, ALU_NONE, JMP_NEXT);
         5'd11: u = cbp_uop(MA_GAIN_D, MB_DIFF_HI, 1'b1, 1'b0, 1'b1, ALU_NONE, JMP_NEXT);
         5'd12: u = cbp_uop(MA_COST_SAD, MB_N_SAD, 1'b0, 1'b0, 1'b0, ALU_NONE, JMP_NEXT);
         5'd13: u = cbp_uop(MA_COST_SAD, MB_N_SAD, 1'b0, 1'b0, 1'b0, ALU_VALUE, JMP_NEXT);
         // Weighting of the controlled value.
         5'd14: u = cbp_uop(MA_WEIGHT, MB_V_LO, 1'b1, 1'b1, 1'b0, ALU_NONE, JMP_NEXT);
         5'd15: u = cbp_uop(MA_WEIGHT, MB_V_HI, 1'b1, 1'b0, 1'b1, ALU_NONE, JMP_NEXT);
         5'd16: u = cbp_uop(MA_COST_SAD, MB_N_SAD, 1'b0, 1'b0, 1'b0, ALU_NONE, JMP_NEXT);
         5'd17: u = cbp_uop(MA_COST_SAD, MB_N_SAD, 1'b0, 1'b0, 1'b0, ALU_BUDGET, JMP_END);
         default: u = cbp_uop(MA_COST_SAD, MB_N_SAD, 1'b0, 1'b0, 1'b0, ALU_NONE, JMP_END);
      endcase
      return u;
   endfunction

endpackage

// ===== src/complexity_budget_pid.sv =====
// Top level of the per-frame cycle budget controller.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_data (frame report)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data (budget, control_on)
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A transaction runs an 18-step microcode program on one shared 17 x 27 multiplier; the
// result passes through the hold state into the rsp output register, and the next request
// is taken only once the sequencer is idle again, so a frame finishes before the next one
// starts. A bypassed frame leaves after step 5.
// Reset is synchronous and clears the registers, the controller state and the sequencer.
// A stalled rsp holds the finished result in the datapath until the output register frees.
module complexity_budget_pid (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  cbp_pkg::cbp_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cbp_pkg::cbp_rsp_type             rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cbp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cbp_pkg::CSR_DATA_W-1:0]   csr_data
);

   cbp_pkg::cbp_cfg_type  cfg;
   cbp_pkg::cbp_ctrl_type ctrl;
   cbp_pkg::cbp_rsp_type  result;
   cbp_pkg::cbp_rsp_type  rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  start;
   logic                  bypass;
   logic                  out_free;
   logic                  push;
   logic                  idle;

   // Request acceptance and output register availability.
   assign req_ready = idle;
   assign start     = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   cbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cbp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .bypass   (bypass),
      .out_free (out_free),
      .ctrl     (ctrl),
      .push     (push),
      .idle     (idle)
   );

   cbp_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .cfg      (cfg),
      .ctrl     (ctrl),
      .bypass   (bypass),
      .result   (result)
   );

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A freshly accepted request cannot produce a result in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      start |=> !push)
      else $error("result handed over straight after acceptance");

endmodule

// ===== src/cbp_csr.sv =====
// Configuration register file of the budget controller.
module cbp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cbp_pkg::CSR_DATA_W-1:0]      csr_data,
   output cbp_pkg::cbp_cfg_type                cfg
);

   cbp_pkg::cbp_cfg_type cfg_ff;
   cbp_pkg::cbp_cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cbp_pkg::REG_SETPOINT:       cfg_in.setpoint       = csr_data[cbp_pkg::SET_W-1:0];
            cbp_pkg::REG_GAIN_P:         cfg_in.gain_p         = csr_data[cbp_pkg::GAIN_W-1:0];
            cbp_pkg::REG_GAIN_I:         cfg_in.gain_i         = csr_data[cbp_pkg::GAIN_W-1:0];
            cbp_pkg::REG_GAIN_D:         cfg_in.gain_d         = csr_data[cbp_pkg::GAIN_W-1:0];
            cbp_pkg::REG_COST_SAD:       cfg_in.cost_sad       = csr_data[cbp_pkg::COST_W-1:0];
            cbp_pkg::REG_COST_SSE:       cfg_in.cost_sse       = csr_data[cbp_pkg::COST_W-1:0];
            cbp_pkg::REG_COST_SATD:      cfg_in.cost_satd      = csr_data[cbp_pkg::COST_W-1:0];
            cbp_pkg::REG_COST_TRANSFORM: cfg_in.cost_transform = csr_data[cbp_pkg::COST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/cbp_seq.sv =====
// Microcode sequencer: step counter, program ROM and end-of-program handling.
module cbp_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  bypass,
   input  logic                  out_free,
   output cbp_pkg::cbp_ctrl_type ctrl,
   output logic                  push,
   output logic                  idle
);

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'b001,
      SEQ_RUN  = 3'b010,
      SEQ_HOLD = 3'b100
   } cbp_seq_state_type;

   cbp_seq_state_type                state_ff;
   cbp_seq_state_type                state_in;
   logic [cbp_pkg::STEP_W-1:0]       step_ff;
   logic [cbp_pkg::STEP_W-1:0]       step_in;
   cbp_pkg::cbp_uop_type             uop;
   logic                             end_now;

   // Fetch the control word of the current step.
   assign uop     = cbp_pkg::cbp_ucode(step_ff);
   assign end_now = (uop.jump == cbp_pkg::JMP_END) ||
                    ((uop.jump == cbp_pkg::JMP_END_IF_BYPASS) && bypass);

   assign ctrl.exec = (state_ff == SEQ_RUN);
   assign ctrl.uop  = uop;
   assign push      = (state_ff == SEQ_HOLD) && out_free;
   assign idle      = (state_ff == SEQ_IDLE);

   // Step counter and run control.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               step_in  = '0;
            end
         end
         SEQ_RUN: begin
            if (end_now) begin
               state_in = SEQ_HOLD;
               step_in  = '0;
            end else begin
               step_in = step_ff + cbp_pkg::STEP_W'(1);
            end
         end
         SEQ_HOLD: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // The step counter only moves while a program runs.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != SEQ_RUN) |-> (step_ff == '0))
      else $error("step counter left non-zero outside a run");

   // Handing a result over ends the transaction.
   assert property (@(posedge clock) disable iff (reset)
      push |=> (state_ff == SEQ_IDLE))
      else $error("sequencer not idle after handing over a result");

endmodule

// ===== src/cbp_dp.sv =====
// Datapath: shared multiplier, accumulator, controller state and result register.
module cbp_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  cbp_pkg::cbp_req_type  req_data,
   input  cbp_pkg::cbp_cfg_type  cfg,
   input  cbp_pkg::cbp_ctrl_type ctrl,
   output logic                  bypass,
   output cbp_pkg::cbp_rsp_type  result
);

   localparam int ACC_W  = cbp_pkg::ACC_W;
   localparam int PROD_W = cbp_pkg::PROD_W;
   localparam int CH     = cbp_pkg::CHUNK_W;
   localparam logic signed [cbp_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(cbp_pkg::SUM_W-1){1'b1}}};
   localparam logic signed [cbp_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(cbp_pkg::SUM_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] V_CAP = ACC_W'(1) <<< (cbp_pkg::V_W - 1);

   // Item and multiplier pipeline.
   cbp_pkg::cbp_req_type                 item_ff, item_in;
   logic signed [PROD_W-1:0]             prod_ff, prod_in;
   logic                                 prod_vld_ff, prod_vld_in;
   logic                                 prod_load_ff, prod_load_in;
   logic                                 prod_hi_ff, prod_hi_in;
   logic signed [ACC_W-1:0]              acc_ff, acc_in;

   // Scratch values of one transaction.
   logic [cbp_pkg::ACH_W-1:0]            achieved_ff, achieved_in;
   logic signed [cbp_pkg::ERR_W-1:0]     err_ff, err_in;
   logic signed [cbp_pkg::DIFF_W-1:0]    diff_ff, diff_in;
   logic                                 clear_sum_ff, clear_sum_in;
   logic [cbp_pkg::V_W-1:0]              v_ff, v_in;
   logic                                 vpos_ff, vpos_in;
   cbp_pkg::cbp_rsp_type                 result_ff, result_in;

   // Controller state.
   logic signed [cbp_pkg::ERR_W-1:0]     last_err_ff, last_err_in;
   logic signed [cbp_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [cbp_pkg::OFF_W-1:0]            off_ff, off_in;
   logic                                 active_ff, active_in;

   // Combinational helpers.
   logic signed [cbp_pkg::MUL_A_W-1:0]   mul_a;
   logic signed [cbp_pkg::MUL_B_W-1:0]   mul_b;
   logic signed [ACC_W-1:0]              term_ext;
   logic signed [ACC_W-1:0]              term;
   logic [cbp_pkg::ACH_W-1:0]            achieved;
   logic signed [cbp_pkg::ERR_W-1:0]     err_calc;
   logic                                 below;
   logic                                 frame_hold;
   logic [cbp_pkg::OFF_W-1:0]            off_next;
   logic [cbp_pkg::WT_W-1:0]             weight;
   logic signed [cbp_pkg::SUM_W-1:0]     sum_base;
   logic signed [cbp_pkg::SUM_W:0]       sum_wide;
   logic signed [cbp_pkg::SUM_W-1:0]     sum_sat;
   logic signed [ACC_W-1:0]              v_calc;
   logic [ACC_W-9:0]                     scaled;

   assign result = result_ff;

   // Group-position weight of the current item.
   assign weight = item_ff.group_is_eight ? cbp_pkg::WEIGHT8[item_ff.picture_order[2:0]]
                                          : cbp_pkg::WEIGHT4[item_ff.picture_order[1:0]];

   // First multiplier operand: costs and weight zero-extended, gains sign-extended.
   always_comb begin
      unique case (ctrl.uop.mul_a)
         cbp_pkg::MA_COST_SAD:       mul_a = {1'b0, cfg.cost_sad};
         cbp_pkg::MA_COST_SSE:       mul_a = {1'b0, cfg.cost_sse};
         cbp_pkg::MA_COST_SATD:      mul_a = {1'b0, cfg.cost_satd};
         cbp_pkg::MA_COST_TRANSFORM: mul_a = {1'b0, cfg.cost_transform};
         cbp_pkg::MA_GAIN_P:         mul_a = {cfg.gain_p[cbp_pkg::GAIN_W-1], cfg.gain_p};
         cbp_pkg::MA_GAIN_I:         mul_a = {cfg.gain_i[cbp_pkg::GAIN_W-1], cfg.gain_i};
         cbp_pkg::MA_GAIN_D:         mul_a = {cfg.gain_d[cbp_pkg::GAIN_W-1], cfg.gain_d};
         cbp_pkg::MA_WEIGHT:         mul_a = {7'b0, weight};
         default:                    mul_a = '0;
      endcase
   end

   // Second operand: counts, or the low (unsigned) or high (signed, but unsigned for v) chunk of a wide value.
   always_comb begin
      unique case (ctrl.uop.mul_b)
         cbp_pkg::MB_N_SAD:       mul_b = {3'b0, item_ff.sad_ops & cbp_pkg::COUNT_MASK};
         cbp_pkg::MB_N_SSE:       mul_b = {3'b0, item_ff.sse_ops & cbp_pkg::COUNT_MASK};
         cbp_pkg::MB_N_SATD:      mul_b = {3'b0, item_ff.satd_ops & cbp_pkg::COUNT_MASK};
         cbp_pkg::MB_N_TRANSFORM: mul_b = {3'b0, item_ff.transform_ops & cbp_pkg::COUNT_MASK};
         cbp_pkg::MB_ERR_LO:      mul_b = {1'b0, err_ff[CH-1:0]};
         cbp_pkg::MB_ERR_HI:      mul_b = {{9{err_ff[cbp_pkg::ERR_W-1]}},
                                           err_ff[cbp_pkg::ERR_W-1:CH]};
         cbp_pkg::MB_SUM_LO:      mul_b = {1'b0, sum_ff[CH-1:0]};
         cbp_pkg::MB_SUM_HI:      mul_b = {{5{sum_ff[cbp_pkg::SUM_W-1]}},
                                           sum_ff[cbp_pkg::SUM_W-1:CH]};
         cbp_pkg::MB_DIFF_LO:     mul_b = {1'b0, diff_ff[CH-1:0]};
         cbp_pkg::MB_DIFF_HI:     mul_b = {{8{diff_ff[cbp_pkg::DIFF_W-1]}},
                                           diff_ff[cbp_pkg::DIFF_W-1:CH]};
         cbp_pkg::MB_V_LO:        mul_b = {1'b0, v_ff[CH-1:0]};
         cbp_pkg::MB_V_HI:        mul_b = {2'b0, v_ff[cbp_pkg::V_W-1:CH]};
         default:                 mul_b = '0;
      endcase
   end

   // Registered product, sign-extended and placed at its chunk position.
   assign term_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign term     = prod_hi_ff ? (term_ext <<< CH) : term_ext;

   // Bypass decision on the finished achieved cost.
   assign achieved   = acc_ff[cbp_pkg::ACH_W-1:0];
   assign err_calc   = {2'b00, cfg.setpoint} - {2'b00, achieved};
   assign below      = !err_calc[cbp_pkg::ERR_W-1] && (err_calc != '0);
   assign frame_hold = (item_ff.frame_number >= cbp_pkg::FRAME_W'(cbp_pkg::FRAME_HOLD_LO)) &&
                       (item_ff.frame_number <  cbp_pkg::FRAME_W'(cbp_pkg::FRAME_HOLD_HI));
   assign bypass     = (below && !active_ff) || frame_hold;
   assign off_next   = below ? off_ff + cbp_pkg::OFF_W'(1) : off_ff;

   // Saturating accumulation of the error.
   assign sum_base = clear_sum_ff ? '0 : sum_ff;
   assign sum_wide = {sum_base[cbp_pkg::SUM_W-1], sum_base} +
                     {{(cbp_pkg::SUM_W+1-cbp_pkg::ERR_W){err_ff[cbp_pkg::ERR_W-1]}}, err_ff};
   assign sum_sat  = (sum_wide[cbp_pkg::SUM_W] != sum_wide[cbp_pkg::SUM_W-1]) ?
                     (sum_wide[cbp_pkg::SUM_W] ? SUM_MIN : SUM_MAX) :
                     sum_wide[cbp_pkg::SUM_W-1:0];

   // Achieved cost plus the floored PID sum, and the weighted budget. The sum stays signed
   // so that the shift floors a negative PID sum.
   assign v_calc = (acc_ff >>> 8) +
                   $signed({{(ACC_W-cbp_pkg::ACH_W){1'b0}}, achieved_ff});
   assign scaled = acc_ff[ACC_W-1:8];

   always_comb begin
      item_in      = start ? req_data : item_ff;
      prod_in      = mul_a * mul_b;
      prod_vld_in  = ctrl.exec && ctrl.uop.mul_en;
      prod_load_in = ctrl.uop.acc_load;
      prod_hi_in   = ctrl.uop.shift_hi;
      acc_in       = acc_ff;
      if (prod_vld_ff) begin
         acc_in = prod_load_ff ? term : acc_ff + term;
      end
      achieved_in  = achieved_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      clear_sum_in = clear_sum_ff;
      v_in         = v_ff;
      vpos_in      = vpos_ff;
      result_in    = result_ff;
      last_err_in  = last_err_ff;
      sum_in       = sum_ff;
      off_in       = off_ff;
      active_in    = active_ff;
      if (ctrl.exec) begin
         unique case (ctrl.uop.alu)
            cbp_pkg::ALU_NONE: ;
            cbp_pkg::ALU_DECIDE: begin
               if (bypass) begin
                  active_in            = 1'b0;
                  off_in               = '0;
                  result_in.budget     = {{(cbp_pkg::BUDGET_W-cbp_pkg::SET_W){1'b0}},
                                          cfg.setpoint};
                  result_in.control_on = 1'b0;
               end else begin
                  achieved_in = achieved;
                  err_in      = err_calc;
                  if (off_next < cbp_pkg::OFF_W'(cbp_pkg::OFF_LIMIT)) begin
                     active_in    = 1'b1;
                     off_in       = off_next;
                     clear_sum_in = 1'b0;
                  end else begin
                     active_in    = 1'b0;
                     off_in       = '0;
                     clear_sum_in = 1'b1;
                  end
               end
            end
            cbp_pkg::ALU_SUM: begin
               sum_in      = sum_sat;
               diff_in     = {err_ff[cbp_pkg::ERR_W-1], err_ff} -
                             {last_err_ff[cbp_pkg::ERR_W-1], last_err_ff};
               last_err_in = err_ff;
            end
            cbp_pkg::ALU_VALUE: begin
               vpos_in = !v_calc[ACC_W-1] && (v_calc != '0);
               v_in    = (v_calc > V_CAP) ? {1'b1, {(cbp_pkg::V_W-1){1'b0}}}
                                          : v_calc[cbp_pkg::V_W-1:0];
            end
            cbp_pkg::ALU_BUDGET: begin
               if (!vpos_ff) begin
                  result_in.budget = '0;
               end else if (|scaled[ACC_W-9:cbp_pkg::BUDGET_W]) begin
                  result_in.budget = '1;
               end else begin
                  result_in.budget = scaled[cbp_pkg::BUDGET_W-1:0];
               end
               result_in.control_on = active_ff;
            end
            default: ;
         endcase
      end
   end

   // Controller state and multiplier valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         last_err_ff <= '0;
         sum_ff      <= '0;
         off_ff      <= '0;
         active_ff   <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         last_err_ff <= last_err_in;
         sum_ff      <= sum_in;
         off_ff      <= off_in;
         active_ff   <= active_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      prod_ff      <= prod_in;
      prod_load_ff <= prod_load_in;
      prod_hi_ff   <= prod_hi_in;
      acc_ff       <= acc_in;
      achieved_ff  <= achieved_in;
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      clear_sum_ff <= clear_sum_in;
      v_ff         <= v_in;
      vpos_ff      <= vpos_in;
      result_ff    <= result_in;
   end

   // An inactive controller always has its off counter cleared.
   assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (off_ff == '0))
      else $error("off counter non-zero while the controller is off");

   // The off counter never rests at the limit.
   assert property (@(posedge clock) disable iff (reset)
      off_ff < cbp_pkg::OFF_W'(cbp_pkg::OFF_LIMIT))
      else $error("off counter reached the limit without switching off");

endmodule

// ===== verif/complexity_budget_pid_test.sv =====
// Self-checking testbench for the per-frame cycle budget controller.
`timescale 1ns / 100ps

module complexity_budget_pid_test;
   import cbp_pkg::*;

   localparam int          TAIL_CYCLES  = 40;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          PHASES       = 12;
   localparam int          PHASE_ITEMS  = 111;
   localparam int          LONG_HOLD    = 300;
   localparam int          HOLD_AT      = 500;
   localparam logic [SET_W-1:0] SP_MAX  = {SET_W{1'b1}};

   // Saturation bounds of the error, the accumulator, the controlled value and the budget.
   localparam longint ERR_TOP    = (longint'(1) <<< (ERR_W - 1)) - 1;
   localparam longint SUM_TOP    = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint VALUE_CAP  = longint'(1) <<< 50;
   localparam longint BUDGET_TOP = (longint'(1) <<< BUDGET_W) - 1;

   // Group-position weights in Q2.8.
   localparam int unsigned GOP8_WEIGHT [8] = '{666, 333, 220, 166, 166, 220, 166, 166};
   localparam int unsigned GOP4_WEIGHT [4] = '{154, 230, 154, 461};

   typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      cbp_reg_type           reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      cbp_req_type           report;
      bit                    typed;
      cbp_rsp_type           answer;
   } plan_row_type;

   typedef struct {
      bit          typed;
      cbp_rsp_type answer;
   } answer_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   cbp_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   cbp_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Shadow of the registers and of the controller state.
   cbp_cfg_type     shadow     = '0;
   longint          last_error = 0;
   longint          error_sum  = 0;
   logic [OFF_W-1:0] off_count = '0;
   logic            ctl_active = 1'b0;

   cbp_rsp_type     budget_q [$];
   answer_type      answer_q [$];
   plan_row_type    plan_q [$];

   int              sent_count    = 0;
   int              rsp_count     = 0;
   int              fault_count   = 0;
   int              bypass_count  = 0;
   int              shutoff_count = 0;
   int              write_count   = 0;
   int unsigned     cycle_count   = 0;
   int unsigned     count_cap     = 32'hFFFFFF;

   complexity_budget_pid dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the budget for one frame report and advances the controller state.
   function automatic cbp_rsp_type forecast_budget(input cbp_req_type rpt);
      longint unsigned achieved;
      longint          ach, sp, err, prev, acc, pid, v, gp, gi, gd, b;
      int unsigned     weight;
      logic            below;
      cbp_rsp_type     res;
      achieved = 64'(rpt.sad_ops & COUNT_MASK) * 64'(shadow.cost_sad)
               + 64'(rpt.sse_ops & COUNT_MASK) * 64'(shadow.cost_sse)
               + 64'(rpt.satd_ops & COUNT_MASK) * 64'(shadow.cost_satd)
               + 64'(rpt.transform_ops & COUNT_MASK) * 64'(shadow.cost_transform);
      ach   = achieved;
      sp    = shadow.setpoint;
      below = sp > ach;
      if ((below && !ctl_active) ||
          (rpt.frame_number >= FRAME_HOLD_LO && rpt.frame_number < FRAME_HOLD_HI)) begin
         ctl_active     = 1'b0;
         off_count      = '0;
         res.budget     = BUDGET_W'(shadow.setpoint);
         res.control_on = 1'b0;
         bypass_count++;
         return res;
      end
      // The off counter only moves while the setpoint is still out of reach.
      if (below) off_count = off_count + 4'd1;
      if (off_count < OFF_LIMIT) begin
         ctl_active = 1'b1;
      end else begin
         ctl_active = 1'b0;
         off_count  = '0;
         error_sum  = 0;
         shutoff_count++;
      end
      err = sp - ach;
      if (err > ERR_TOP) err = ERR_TOP;
      if (err < -ERR_TOP - 1) err = -ERR_TOP - 1;
      error_sum = error_sum + err;
      if (error_sum > SUM_TOP) error_sum = SUM_TOP;
      if (error_sum < -SUM_TOP - 1) error_sum = -SUM_TOP - 1;
      prev       = last_error;
      last_error = err;
      gp  = $signed(shadow.gain_p);
      gi  = $signed(shadow.gain_i);
      gd  = $signed(shadow.gain_d);
      acc = gp * err + gi * error_sum + gd * (err - prev);
      pid = acc >>> 8;
      v   = ach + pid;
      weight = rpt.group_is_eight ? GOP8_WEIGHT[rpt.picture_order[2:0]]
                                  : GOP4_WEIGHT[rpt.picture_order[1:0]];
      if (v <= 0) begin
         b = 0;
      end else begin
         if (v > VALUE_CAP) v = VALUE_CAP;
         b = (v * longint'(weight)) >>> 8;
         if (b > BUDGET_TOP) b = BUDGET_TOP;
      end
      res.budget     = b[BUDGET_W-1:0];
      res.control_on = ctl_active;
      return res;
   endfunction

   function automatic cbp_req_type make_report(input int unsigned sad, input int unsigned sse,
                                               input int unsigned satd, input int unsigned xfm,
                                               input int unsigned frame, input int unsigned poc,
                                               input bit eight);
      cbp_req_type rpt;
      rpt.sad_ops        = COUNT_FIELD_W'(sad);
      rpt.sse_ops        = COUNT_FIELD_W'(sse);
      rpt.satd_ops       = COUNT_FIELD_W'(satd);
      rpt.transform_ops  = COUNT_FIELD_W'(xfm);
      rpt.frame_number   = FRAME_W'(frame);
      rpt.picture_order  = POC_W'(poc);
      rpt.group_is_eight = eight;
      return rpt;
   endfunction

   function automatic void plan_write(input cbp_reg_type idx, input logic [CSR_DATA_W-1:0] v);
      plan_row_type row;
      row.kind      = ROW_WRITE;
      row.reg_index = idx;
      row.reg_value = v;
      row.report    = '0;
      row.typed     = 1'b0;
      row.answer    = '0;
      plan_q.push_back(row);
   endfunction

   function automatic void plan_frame(input cbp_req_type rpt, input bit typed,
                                      input logic [BUDGET_W-1:0] b, input logic on);
      plan_row_type row;
      row.kind              = ROW_FRAME;
      row.reg_index         = REG_SETPOINT;
      row.reg_value         = '0;
      row.report            = rpt;
      row.typed             = typed;
      row.answer.budget     = b;
      row.answer.control_on = on;
      plan_q.push_back(row);
   endfunction

   // Operation count within the range chosen for the current phase, now and then any value.
   function automatic logic [COUNT_FIELD_W-1:0] pick_count();
      if ($urandom_range(0, 15) == 0) return COUNT_FIELD_W'($urandom);
      return COUNT_FIELD_W'($urandom_range(0, count_cap));
   endfunction

   function automatic cbp_req_type random_report();
      cbp_req_type rpt;
      rpt.sad_ops       = pick_count();
      rpt.sse_ops       = pick_count();
      rpt.satd_ops      = pick_count();
      rpt.transform_ops = pick_count();
      // Mostly frames outside the forced-off window, a tenth of them inside it.
      if ($urandom_range(0, 9) == 0) begin
         rpt.frame_number = FRAME_W'($urandom_range(FRAME_HOLD_LO, FRAME_HOLD_HI - 1));
      end else begin
         rpt.frame_number = FRAME_W'($urandom);
         if (rpt.frame_number >= FRAME_HOLD_LO && rpt.frame_number < FRAME_HOLD_HI)
            rpt.frame_number = rpt.frame_number + 16'd128;
      end
      rpt.picture_order  = POC_W'($urandom);
      rpt.group_is_eight = 1'($urandom_range(0, 1));
      return rpt;
   endfunction

   // Offers one frame report after the given gap and returns at the edge it is taken.
   task automatic send_report(input cbp_req_type rpt, input int gap, input bit typed,
                              input cbp_rsp_type answer);
      answer_type hint;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      hint.typed  = typed;
      hint.answer = answer;
      answer_q.push_back(hint);
      req_data  <= rpt;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Stops offering and waits until every outstanding budget has come back.
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      while (rsp_count != sent_count) @(posedge clock);
   endtask

   // Leaves csr_valid high so that back-to-back writes need no idle cycle.
   task automatic write_reg(input cbp_reg_type idx, input logic [CSR_DATA_W-1:0] v);
      csr_index <= idx;
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Shadow update on every register write and check of every completed budget.
   always @(posedge clock) begin
      cbp_rsp_type want;
      answer_type  hint;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            write_count++;
            case (cbp_reg_type'(csr_index))
               REG_SETPOINT:       shadow.setpoint       = csr_data[SET_W-1:0];
               REG_GAIN_P:         shadow.gain_p         = csr_data[GAIN_W-1:0];
               REG_GAIN_I:         shadow.gain_i         = csr_data[GAIN_W-1:0];
               REG_GAIN_D:         shadow.gain_d         = csr_data[GAIN_W-1:0];
               REG_COST_SAD:       shadow.cost_sad       = csr_data[COST_W-1:0];
               REG_COST_SSE:       shadow.cost_sse       = csr_data[COST_W-1:0];
               REG_COST_SATD:      shadow.cost_satd      = csr_data[COST_W-1:0];
               REG_COST_TRANSFORM: shadow.cost_transform = csr_data[COST_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = forecast_budget(req_data);
            if (answer_q.size() != 0) begin
               hint = answer_q.pop_front();
               if (hint.typed) want = hint.answer;
            end
            budget_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (budget_q.size() == 0) begin
               $display("%0t ns: unexpected budget, expected none, actual %0d/%0b",
                        $time, rsp_data.budget, rsp_data.control_on);
               fault_count++;
            end else begin
               want = budget_q.pop_front();
               if (rsp_data.budget !== want.budget) begin
                  $display("%0t ns: budget mismatch, expected %0d, actual %0d",
                           $time, want.budget, rsp_data.budget);
                  fault_count++;
               end
               if (rsp_data.control_on !== want.control_on) begin
                  $display("%0t ns: control_on mismatch, expected %0b, actual %0b",
                           $time, want.control_on, rsp_data.control_on);
                  fault_count++;
               end
            end
         end
      end
   end

   // Result side: random stalls, bursts without any, and one long hold-off.
   initial begin
      int taken;
      int pause;
      taken = 0;
      while (reset) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            taken++;
            if (taken == HOLD_AT) pause = LONG_HOLD;
            else if (taken % 256 < 48) pause = 0;
            else pause = $urandom_range(0, 4);
            if (pause > 0) begin
               rsp_ready <= 1'b0;
               repeat (pause) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d budgets outstanding.",
                  cycle_count, budget_q.size());
         $display("FAIL complexity_budget_pid");
         $finish;
      end
   end

   // Stimulus: directed table first, then random phases under changing settings.
   initial begin
      plan_row_type          row;
      cbp_rsp_type           none;
      logic [CSR_DATA_W-1:0] vals [8];
      logic [COST_W-1:0]     cost_pick [4];
      logic [GAIN_W-1:0]     gain;
      longint unsigned       sp;
      int unsigned           cost_cap;
      int                    gap;

      none = '0;

      // Registers at reset: nothing costs anything, so the budget is zero.
      plan_frame(make_report(0, 0, 0, 0, 0, 0, 1'b0), 1'b1, '0, 1'b1);
      plan_frame(make_report(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF,
                             32'hFFFF, 32'hFFFF, 1'b1), 1'b1, '0, 1'b1);
      plan_frame(make_report(0, 0, 0, 0, 64, 5, 1'b1), 1'b1, '0, 1'b0);
      plan_frame(make_report(0, 0, 0, 0, 127, 6, 1'b0), 1'b1, '0, 1'b0);
      plan_frame(make_report(0, 0, 0, 0, 128, 7, 1'b0), 1'b1, '0, 1'b1);
      // Largest setpoint, gains and costs.
      plan_write(REG_SETPOINT, SP_MAX);
      plan_write(REG_GAIN_P, 42'h7FFF);
      plan_write(REG_GAIN_I, 42'h8000);
      plan_write(REG_GAIN_D, 42'h7FFF);
      plan_write(REG_COST_SAD, 42'hFFFF);
      plan_write(REG_COST_SSE, 42'hFFFF);
      plan_write(REG_COST_SATD, 42'hFFFF);
      plan_write(REG_COST_TRANSFORM, 42'hFFFF);
      plan_frame(make_report(0, 0, 0, 0, 200, 0, 1'b1), 1'b0, '0, 1'b0);
      plan_frame(make_report(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF,
                             201, 3, 1'b0), 1'b0, '0, 1'b0);
      // Forced-off window, then a setpoint still out of reach while inactive.
      plan_frame(make_report(0, 0, 0, 0, 100, 1, 1'b1), 1'b1, BUDGET_W'(SP_MAX), 1'b0);
      plan_frame(make_report(0, 0, 0, 0, 300, 2, 1'b1), 1'b1, BUDGET_W'(SP_MAX), 1'b0);
      // Zero setpoint against the largest cost, most negative P and D gains, largest I gain.
      plan_write(REG_SETPOINT, '0);
      plan_write(REG_GAIN_P, 42'h8000);
      plan_write(REG_GAIN_I, 42'h7FFF);
      plan_write(REG_GAIN_D, 42'h8000);
      plan_frame(make_report(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF,
                             400, 0, 1'b1), 1'b0, '0, 1'b0);
      // Modest gains; eight short frames in a row run the off counter to its limit
      // while sweeping the eight-entry weights.
      plan_write(REG_SETPOINT, 42'd1000);
      plan_write(REG_GAIN_P, 42'h0100);
      plan_write(REG_GAIN_I, 42'h0040);
      plan_write(REG_GAIN_D, 42'h0020);
      plan_write(REG_COST_SAD, 42'd1);
      plan_write(REG_COST_SSE, '0);
      plan_write(REG_COST_SATD, '0);
      plan_write(REG_COST_TRANSFORM, '0);
      plan_frame(make_report(2000, 0, 0, 0, 500, 0, 1'b0), 1'b0, '0, 1'b0);
      for (int k = 0; k < 8; k++)
         plan_frame(make_report(0, 0, 0, 0, 501 + k, k, 1'b1), 1'b0, '0, 1'b0);
      plan_frame(make_report(0, 0, 0, 0, 520, 1, 1'b0), 1'b1, 48'd1000, 1'b0);
      plan_frame(make_report(2000, 0, 0, 0, 521, 2, 1'b0), 1'b0, '0, 1'b0);
      plan_frame(make_report(3000, 0, 0, 0, 522, 3, 1'b0), 1'b0, '0, 1'b0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_q[i]) begin
         row = plan_q[i];
         if (row.kind == ROW_WRITE) begin
            drain();
            write_reg(row.reg_index, row.reg_value);
         end else begin
            if (csr_valid) csr_valid <= 1'b0;
            send_report(row.report, $urandom_range(0, 4), row.typed, row.answer);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         // Ranges for this phase; the setpoint is the cost of a typical frame so that frames fall
         // on both sides of it, but phases 1 and 2 use a zero and the largest setpoint.
         count_cap = (phase == 0) ? 32'hFFFFFF : (32'd1 << $urandom_range(4, 24)) - 1;
         cost_cap  = (phase == 0) ? 32'hFFFF : (32'd1 << $urandom_range(0, 16)) - 1;
         for (int k = 0; k < 4; k++) cost_pick[k] = COST_W'($urandom_range(0, cost_cap));
         sp = 64'(cost_pick[0]) * pick_count() + 64'(cost_pick[1]) * pick_count()
            + 64'(cost_pick[2]) * pick_count() + 64'(cost_pick[3]) * pick_count();
         if (phase == 1) sp = 0;
         if (phase == 2) sp = SP_MAX;
         vals[REG_SETPOINT] = sp[SET_W-1:0];
         for (int g = 0; g < 3; g++) begin
            if (phase == 3) gain = 16'h8000;
            else if (phase == 4) gain = 16'h7FFF;
            else if (phase % 2 == 0) gain = GAIN_W'($urandom);
            else gain = GAIN_W'($urandom_range(0, 1023) - 512);
            vals[REG_GAIN_P + g] = {26'($urandom), gain};
         end
         for (int k = 0; k < 4; k++)
            vals[REG_COST_SAD + k] = {26'($urandom), cost_pick[k]};
         for (int k = 0; k < 8; k++) write_reg(cbp_reg_type'(k), vals[k]);
         csr_valid <= 1'b0;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            gap = (phase % 3 == 1) ? 0 : $urandom_range(0, 4);
            send_report(random_report(), gap, 1'b0, none);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (budget_q.size() != 0) begin
         $display("%0t ns: %0d budgets never arrived, expected %0d/%0b first", $time,
                  budget_q.size(), budget_q[0].budget, budget_q[0].control_on);
         fault_count++;
      end

      $display("Checked %0d budgets from %0d frame reports over %0d register writes.",
               rsp_count, sent_count, write_count);
      $display("Frames bypassed: %0d, controller turned off at the off limit: %0d times.",
               bypass_count, shutoff_count);
      if (fault_count == 0) begin
         $display("PASS complexity_budget_pid");
      end else begin
         $display("FAIL complexity_budget_pid");
      end
      $finish;
   end

endmodule
